[rtl/core/bcld_pkg.sv]
// Package for the button click / long-press detector.
// Holds the transfer structs, state enum, event codes and register defaults.
// No dependencies.
`timescale 1ns / 1ps

package bcld_pkg;

  localparam int TimeW  = 10;
  localparam int StampW = 6;
  localparam int EventW = 4;
  localparam int CfgIdxW = 3;

  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } bcld_in_t;

  typedef struct packed {
    logic [EventW-1:0] event_code;
    logic              held;
  } bcld_out_t;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_DEBOUNCE  = 4'd1,
    ST_SETTLE    = 4'd2,
    ST_PRESSED   = 4'd3,
    ST_LONG      = 4'd4,
    ST_LONGREL   = 4'd5,
    ST_SHORTREL  = 4'd6,
    ST_PRESSED2  = 4'd7,
    ST_SHORTREL2 = 4'd8,
    ST_LONG2     = 4'd9,
    ST_LONGREL2  = 4'd10
  } bcld_state_t;

  localparam logic [EventW-1:0] EV_NONE        = 4'd0;
  localparam logic [EventW-1:0] EV_SHORT       = 4'd1;
  localparam logic [EventW-1:0] EV_DOUBLE      = 4'd2;
  localparam logic [EventW-1:0] EV_FIRST_LONG  = 4'd3;
  localparam logic [EventW-1:0] EV_LONG        = 4'd4;
  localparam logic [EventW-1:0] EV_LONG_DONE   = 4'd5;
  localparam logic [EventW-1:0] EV_FIRST_LONG2 = 4'd6;
  localparam logic [EventW-1:0] EV_LONG2       = 4'd7;
  localparam logic [EventW-1:0] EV_LONG_DONE2  = 4'd8;

  localparam logic [CfgIdxW-1:0] REG_PRESS_DEBOUNCE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REPEAT           = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_WAIT      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RELEASE_DEBOUNCE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_ENABLE    = 3'd5;

  localparam logic [TimeW-1:0] RST_PRESS_DEBOUNCE   = 10'd48;
  localparam logic [TimeW-1:0] RST_LONG_PRESS       = 10'd512;
  localparam logic [TimeW-1:0] RST_REPEAT           = 10'd256;
  localparam logic [TimeW-1:0] RST_DOUBLE_WAIT      = 10'd256;
  localparam logic [TimeW-1:0] RST_RELEASE_DEBOUNCE = 10'd48;
  localparam logic             RST_DOUBLE_ENABLE    = 1'b1;

endpackage

[rtl/core/button_click_longpress_detector_unit.sv]
// Top level of the button click / long-press detector.
// Depends on bcld_pkg.
//
//   channel | handshake              | payload
//   in      | in_valid / in_ready    | in_data  (bcld_in_t)
//   out     | out_valid / out_ready  | out_data (bcld_out_t)
//   cfg     | cfg_wen                | cfg_index, cfg_data
//
// One transfer per clock cycle unless stalled; each sample updates state and loads
// the result register in the cycle it is accepted.
// The only stall source is the result register: in_ready is low while it
// holds a result that out_ready has not taken.
// rst (synchronous) clears the state to idle, the stamp to zero, the
// registers to their defaults and the result register to empty.
`timescale 1ns / 1ps

module button_click_longpress_detector_unit
  import bcld_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bcld_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bcld_out_t          out_data,
  input  logic               cfg_wen,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_data
);

  logic [TimeW-1:0]  press_debounce_ms;
  logic [TimeW-1:0]  long_press_ms;
  logic [TimeW-1:0]  repeat_ms;
  logic [TimeW-1:0]  double_click_wait_ms;
  logic [TimeW-1:0]  release_debounce_ms;
  logic              double_click_enable;

  bcld_state_t       state, state_next;
  logic [StampW-1:0] stamp, stamp_next;
  logic [EventW-1:0] ev;
  logic              held;
  logic              accept;
  logic              up;
  logic [TimeW-1:0]  now_q, stamp_ms, elapsed;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign up       = in_data.pin_level;
  assign now_q    = {in_data.now_ms[TimeW-1:TimeW-StampW], {(TimeW-StampW){1'b0}}};
  assign stamp_ms = {stamp, {(TimeW-StampW){1'b0}}};
  assign elapsed  = now_q - stamp_ms;  // wraps modulo 1024

  always_ff @(posedge clk) begin
    if (rst) begin
      press_debounce_ms    <= RST_PRESS_DEBOUNCE;
      long_press_ms        <= RST_LONG_PRESS;
      repeat_ms            <= RST_REPEAT;
      double_click_wait_ms <= RST_DOUBLE_WAIT;
      release_debounce_ms  <= RST_RELEASE_DEBOUNCE;
      double_click_enable  <= RST_DOUBLE_ENABLE;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_PRESS_DEBOUNCE:   press_debounce_ms    <= cfg_data;
        REG_LONG_PRESS:       long_press_ms        <= cfg_data;
        REG_REPEAT:           repeat_ms            <= cfg_data;
        REG_DOUBLE_WAIT:      double_click_wait_ms <= cfg_data;
        REG_RELEASE_DEBOUNCE: release_debounce_ms  <= cfg_data;
        REG_DOUBLE_ENABLE:    double_click_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state and stamp
  always_comb begin
    state_next = state;
    stamp_next = stamp;
    unique case (state)
      ST_IDLE: begin
        if (!up) begin
          state_next = ST_DEBOUNCE;
          stamp_next = now_q[TimeW-1:TimeW-StampW];
        end
      end
      ST_DEBOUNCE: begin
        if (up) state_next = ST_IDLE;
        else if (elapsed >= press_debounce_ms) state_next = ST_PRESSED;
      end
      ST_PRESSED, ST_PRESSED2: begin
        if (up) begin
          stamp_next = now_q[TimeW-1:TimeW-StampW];
          state_next = (state == ST_PRESSED) ? ST_SHORTREL : ST_SHORTREL2;
        end else if (elapsed >= long_press_ms) begin
          stamp_next = now_q[TimeW-1:TimeW-StampW];
          state_next = (state == ST_PRESSED) ? ST_LONG : ST_LONG2;
        end
      end
      ST_LONG, ST_LONG2: begin
        if (up) begin
          state_next = (state == ST_LONG) ? ST_LONGREL : ST_LONGREL2;
        end else if (elapsed >= repeat_ms) begin
          stamp_next = now_q[TimeW-1:TimeW-StampW];
        end
      end
      ST_LONGREL, ST_LONGREL2: begin
        if (up) begin
          state_next = ST_SETTLE;
          stamp_next = now_q[TimeW-1:TimeW-StampW];
        end else begin
          state_next = (state == ST_LONGREL) ? ST_LONG : ST_LONG2;
        end
      end
      ST_SHORTREL, ST_SHORTREL2: begin
        if (state == ST_SHORTREL && !double_click_enable) begin
          state_next = up ? ST_SETTLE : ST_PRESSED;
        end else if (up) begin
          if (state == ST_SHORTREL2) state_next = ST_SETTLE;
          else if (elapsed >= double_click_wait_ms) state_next = ST_SETTLE;
        end else if (elapsed >= release_debounce_ms) begin
          state_next = ST_PRESSED2;
        end
      end
      ST_SETTLE: begin
        if (up) begin
          if (elapsed >= release_debounce_ms) state_next = ST_IDLE;
        end else begin
          stamp_next = now_q[TimeW-1:TimeW-StampW];
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // event output
  always_comb begin
    ev = EV_NONE;
    unique case (state)
      ST_PRESSED, ST_PRESSED2: begin
        if (!up && elapsed >= long_press_ms)
          ev = (state == ST_PRESSED) ? EV_FIRST_LONG : EV_FIRST_LONG2;
      end
      ST_LONG, ST_LONG2: begin
        if (!up && elapsed >= repeat_ms)
          ev = (state == ST_LONG) ? EV_LONG : EV_LONG2;
      end
      ST_LONGREL, ST_LONGREL2: begin
        if (up) ev = (state == ST_LONGREL) ? EV_LONG_DONE : EV_LONG_DONE2;
      end
      ST_SHORTREL, ST_SHORTREL2: begin
        if (state == ST_SHORTREL && !double_click_enable) begin
          if (up) ev = EV_SHORT;
        end else if (up) begin
          if (state == ST_SHORTREL2) ev = EV_DOUBLE;
          else if (elapsed >= double_click_wait_ms) ev = EV_SHORT;
        end
      end
      default: ev = EV_NONE;
    endcase
  end

  assign held = (ev == EV_NONE) && (state_next != ST_IDLE) &&
                (state_next != ST_DEBOUNCE) && (state_next != ST_SETTLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stamp     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        stamp     <= stamp_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.event_code <= ev;
      out_data.held       <= held;
    end
  end

endmodule
